/* design/qat_pkg.sv */
// shared types and constants for the quoted argument tokenizer
`default_nettype none
package qat_pkg;

	localparam int ARG_LEN     = 512;
	localparam int MAX_ARGS    = 128;
	localparam int LEN_W       = 10;
	localparam int IDX_W       = 7;
	localparam int QUEUE_DEPTH = 4;
	localparam int PTR_W       = $clog2(QUEUE_DEPTH);
	localparam int CNT_W       = PTR_W + 1;

	localparam logic [7:0] CH_NUL    = 8'h00;
	localparam logic [7:0] CH_SPACE  = 8'h20;
	localparam logic [7:0] CH_BSLASH = 8'h5C;
	localparam logic [7:0] CH_SQUOTE = 8'h27;
	localparam logic [7:0] CH_DQUOTE = 8'h22;

	typedef enum logic [1:0] {
		OP_BYTE = 2'd0,
		OP_PAIR = 2'd1,
		OP_END  = 2'd2,
		OP_EOL  = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		KIND_BYTE = 2'd0,
		KIND_END  = 2'd1,
		KIND_EOL  = 2'd2
	} kind_t;

	typedef enum logic [1:0] {
		QM_NONE   = 2'd0,
		QM_SINGLE = 2'd1,
		QM_DOUBLE = 2'd2
	} qmode_t;

	typedef struct packed {
		op_t        op;
		logic [7:0] ch;
	} cmd_t;

endpackage
`default_nettype wire

/* design/qat_front.sv */
// front end: quote and escape parsing, turns bytes into commands
`default_nettype none
module qat_front
	import qat_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       accept,
	input  wire logic [7:0] ch,
	output logic            push,
	output cmd_t            cmd
);

	logic   in_arg_q, in_arg_n;
	qmode_t qm_q, qm_n;
	logic   esc_q, esc_n;
	logic   has_op;
	logic   is_q;
	qmode_t q;

	always_comb begin
		in_arg_n = in_arg_q;
		qm_n     = qm_q;
		esc_n    = esc_q;
		has_op   = 1'b0;
		cmd.op   = OP_BYTE;
		cmd.ch   = ch;
		is_q     = (ch == CH_SQUOTE) || (ch == CH_DQUOTE);
		q        = (ch == CH_SQUOTE) ? QM_SINGLE : QM_DOUBLE;
		priority if (ch == CH_NUL) begin
			has_op   = 1'b1;
			cmd.op   = OP_EOL;
			in_arg_n = 1'b0;
			qm_n     = QM_NONE;
			esc_n    = 1'b0;
		end else if (ch == CH_SPACE && !in_arg_q) begin
			has_op = 1'b0;
		end else if (ch == CH_SPACE && qm_q == QM_NONE) begin
			has_op   = 1'b1;
			cmd.op   = OP_END;
			in_arg_n = 1'b0;
		end else begin
			in_arg_n = 1'b1;
			priority if (is_q && esc_q && qm_q == q) begin
				has_op = 1'b1;
				esc_n  = 1'b0;
			end else if (is_q && qm_q == QM_NONE) begin
				qm_n = q;
			end else if (is_q && qm_q == q) begin
				qm_n = QM_NONE;
			end else if (ch == CH_BSLASH && esc_q) begin
				has_op = 1'b1;
				esc_n  = 1'b0;
			end else if (ch == CH_BSLASH) begin
				esc_n = 1'b1;
			end else begin
				has_op = 1'b1;
				esc_n  = 1'b0;
				cmd.op = (esc_q && qm_q != QM_NONE) ? OP_PAIR : OP_BYTE;
			end
		end
	end

	assign push = accept && has_op;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_arg_q <= 1'b0;
			qm_q     <= QM_NONE;
			esc_q    <= 1'b0;
		end else if (accept) begin
			in_arg_q <= in_arg_n;
			qm_q     <= qm_n;
			esc_q    <= esc_n;
		end
	end

endmodule
`default_nettype wire

/* design/qat_fifo.sv */
// command queue between front and back end
`default_nettype none
module qat_fifo
	import qat_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic push,
	input  wire cmd_t wr_cmd,
	input  wire logic pop,
	output cmd_t      rd_cmd,
	output logic      full,
	output logic      not_empty
);

	cmd_t             mem [QUEUE_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	assign full      = (count_q == CNT_W'(QUEUE_DEPTH));
	assign not_empty = (count_q != '0);
	assign rd_cmd    = mem[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem[wr_ptr_q] <= wr_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + PTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + PTR_W'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + CNT_W'(1);
			end else if (pop && !push) begin
				count_q <= count_q - CNT_W'(1);
			end
		end
	end

endmodule
`default_nettype wire

/* design/qat_back.sv */
// back end: length and count tracking, result beat generation
`default_nettype none
module qat_back
	import qat_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire cmd_t              head,
	input  wire logic              head_valid,
	output logic                   pop,
	output logic                   m_tvalid,
	input  wire logic              m_tready,
	output kind_t                  kind,
	output logic [7:0]             out_char,
	output logic [IDX_W-1:0]       arg_index,
	output logic                   dropped,
	output logic                   last
);

	logic [LEN_W-1:0] len_q, len_n;
	logic [IDX_W-1:0] cnt_q, cnt_n;
	logic             phase_q;
	logic             valid_q;
	kind_t            kind_q, kind_n;
	logic [7:0]       char_q, char_n;
	logic [IDX_W-1:0] idx_q;
	logic             drop_q, drop_n;
	logic             last_q, last_n;
	logic             load;
	logic             len_over;
	logic             args_full;
	logic             is_end;
	logic             is_eol;

	assign load      = head_valid && (!valid_q || m_tready);
	assign len_over  = (len_q >= LEN_W'(ARG_LEN - 1));
	assign args_full = (cnt_q >= IDX_W'(MAX_ARGS - 1));
	assign is_end    = (head.op == OP_END) ||
	                   (head.op == OP_EOL && !phase_q && len_q != '0);
	assign is_eol    = (head.op == OP_EOL) && !is_end;

	always_comb begin
		len_n  = len_q;
		cnt_n  = cnt_q;
		kind_n = KIND_BYTE;
		char_n = head.ch;
		drop_n = len_over || args_full;
		last_n = 1'b1;
		priority if (is_end) begin
			kind_n = KIND_END;
			char_n = '0;
			drop_n = args_full;
			last_n = (head.op == OP_END);
			len_n  = '0;
			if (!args_full) begin
				cnt_n = cnt_q + IDX_W'(1);
			end
		end else if (is_eol) begin
			kind_n = KIND_EOL;
			char_n = '0;
			drop_n = 1'b0;
			len_n  = '0;
			cnt_n  = '0;
		end else begin
			if (head.op == OP_PAIR && !phase_q) begin
				char_n = CH_BSLASH;
				last_n = 1'b0;
			end
			if (!len_over) begin
				len_n = len_q + LEN_W'(1);
			end
		end
	end

	assign pop = load && last_n;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q   <= '0;
			cnt_q   <= '0;
			phase_q <= 1'b0;
			valid_q <= 1'b0;
		end else begin
			if (load) begin
				len_q   <= len_n;
				cnt_q   <= cnt_n;
				phase_q <= !last_n;
				valid_q <= 1'b1;
			end else if (m_tready) begin
				valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			kind_q <= kind_n;
			char_q <= char_n;
			idx_q  <= cnt_q;
			drop_q <= drop_n;
			last_q <= last_n;
		end
	end

	assign m_tvalid  = valid_q;
	assign kind      = kind_q;
	assign out_char  = char_q;
	assign arg_index = idx_q;
	assign dropped   = drop_q;
	assign last      = last_q;

	a_eol_closes: assert property (@(posedge clk) disable iff (!arst_n)
		valid_q && kind_q == KIND_EOL |-> last_q && !drop_q)
		else $error("end of line beat not final or flagged dropped");

	a_eol_clears: assert property (@(posedge clk) disable iff (!arst_n)
		load && is_eol |=> len_q == '0 && cnt_q == '0)
		else $error("counters not cleared after end of line");

	a_phase_holds_head: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q |-> head_valid && (head.op == OP_PAIR || head.op == OP_EOL))
		else $error("second beat pending without its command");

	a_len_bound: assert property (@(posedge clk) disable iff (!arst_n)
		len_q <= LEN_W'(ARG_LEN - 1))
		else $error("argument length beyond limit");

endmodule
`default_nettype wire

/* design/quoted_argument_tokenizer_core.sv */
// top level of the quoted argument tokenizer
//
// input channel s_*: one command-line byte per beat in s_tdata; byte 0 ends
// the line. output channel m_*: one result per beat, kind in m_tuser, the
// argument byte, argument number and drop flag in m_tdata, m_tlast on the
// final result caused by an input byte.
// the front end parses quotes and escapes and accepts a byte every cycle
// while its four-entry command queue has room; the back end tracks argument
// length and count and fills a single output register.
// with the queue empty, a byte is written into the queue and then loaded into
// the output register, which raises m_tvalid. throughput: one byte per cycle
// while the queue has room; a byte that yields two results (lone backslash
// before a byte in quotes, or argument end before end of line) holds the back
// end for a second beat, absorbed by the queue while it has room.
// when m_tready is low the output register holds its beat, the queue fills
// and s_tready drops once four commands wait.
// reset clears the parse state, counters, queue and output valid.
`default_nettype none
module quoted_argument_tokenizer_core
	import qat_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [7:0]  s_tdata,   // [7:0] ch
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [15:0]      m_tdata,   // [7:0] out_char, [14:8] arg_index, [15] dropped
	output logic [1:0]       m_tuser,   // [1:0] kind
	output logic             m_tlast
);

	logic             accept;
	logic             push;
	cmd_t             wr_cmd;
	cmd_t             head;
	logic             pop;
	logic             full;
	logic             not_empty;
	kind_t            kind;
	logic [7:0]       out_char;
	logic [IDX_W-1:0] arg_index;
	logic             dropped;

	assign s_tready = !full;
	assign accept   = s_tvalid && s_tready;

	qat_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.accept (accept),
		.ch     (s_tdata),
		.push   (push),
		.cmd    (wr_cmd)
	);

	qat_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.wr_cmd    (wr_cmd),
		.pop       (pop),
		.rd_cmd    (head),
		.full      (full),
		.not_empty (not_empty)
	);

	qat_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head       (head),
		.head_valid (not_empty),
		.pop        (pop),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.kind       (kind),
		.out_char   (out_char),
		.arg_index  (arg_index),
		.dropped    (dropped),
		.last       (m_tlast)
	);

	assign m_tdata = {dropped, arg_index, out_char};
	assign m_tuser = kind;

endmodule
`default_nettype wire
